[hdl/rmth_pkg.sv]
package rmth_pkg;
    localparam int HEAP_DEPTH = 1024;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_POP_RD_TOP,
        ST_POP_RD_LAST,
        ST_POP_LD_LAST,
        ST_POP_RD_L,
        ST_POP_RD_R,
        ST_POP_CMP,
        ST_PUSH_START,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_MED_RD,
        ST_MED_LD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic decide;
        logic pop_rd_top;
        logic pop_rd_last;
        logic pop_ld_last;
        logic pop_rd_l;
        logic pop_rd_r;
        logic pop_step;
        logic pop_fin;
        logic push_start;
        logic push_rd;
        logic push_step;
        logic push_fin;
        logic med_rd;
        logic med_ld;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic dropped;
        logic move;
        logic pop_leaf;
        logic pop_stop;
        logic push_root;
        logic push_stop;
        logic push_more;
    } t_sts;
endpackage

[hdl/rmth_ram.sv]
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/rmth_ctrl.sv]
module rmth_ctrl import rmth_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // idle may accept while a result beat waits; ST_OUT holds until it drains
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:          if (i_in_valid) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_sts.dropped) n_state = ST_OUT;
                else if (i_sts.move) n_state = ST_POP_RD_TOP;
                else n_state = ST_PUSH_START;
            end
            ST_POP_RD_TOP:    n_state = ST_POP_RD_LAST;
            ST_POP_RD_LAST:   n_state = ST_POP_LD_LAST;
            ST_POP_LD_LAST:   n_state = ST_POP_RD_L;
            ST_POP_RD_L: begin
                if (i_sts.pop_leaf) n_state = ST_PUSH_START;
                else n_state = ST_POP_RD_R;
            end
            ST_POP_RD_R:      n_state = ST_POP_CMP;
            ST_POP_CMP: begin
                if (i_sts.pop_stop) n_state = ST_PUSH_START;
                else n_state = ST_POP_RD_L;
            end
            ST_PUSH_START:    n_state = ST_PUSH_RD;
            ST_PUSH_RD: begin
                if (!i_sts.push_root) n_state = ST_PUSH_CMP;
                else if (i_sts.push_more) n_state = ST_PUSH_START;
                else n_state = ST_MED_RD;
            end
            ST_PUSH_CMP: begin
                if (!i_sts.push_stop) n_state = ST_PUSH_RD;
                else if (i_sts.push_more) n_state = ST_PUSH_START;
                else n_state = ST_MED_RD;
            end
            ST_MED_RD:        n_state = ST_MED_LD;
            ST_MED_LD:        n_state = ST_OUT;
            ST_OUT:           if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:          n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_DECIDE:        o_cmd.decide = 1'b1;
            ST_POP_RD_TOP:    o_cmd.pop_rd_top = 1'b1;
            ST_POP_RD_LAST:   o_cmd.pop_rd_last = 1'b1;
            ST_POP_LD_LAST:   o_cmd.pop_ld_last = 1'b1;
            ST_POP_RD_L: begin
                if (i_sts.pop_leaf) o_cmd.pop_fin = 1'b1;
                else o_cmd.pop_rd_l = 1'b1;
            end
            ST_POP_RD_R:      o_cmd.pop_rd_r = 1'b1;
            ST_POP_CMP:       o_cmd.pop_step = 1'b1;
            ST_PUSH_START:    o_cmd.push_start = 1'b1;
            ST_PUSH_RD: begin
                if (i_sts.push_root) o_cmd.push_fin = 1'b1;
                else o_cmd.push_rd = 1'b1;
            end
            ST_PUSH_CMP:      o_cmd.push_step = 1'b1;
            ST_MED_RD:        o_cmd.med_rd = 1'b1;
            ST_MED_LD:        o_cmd.med_ld = 1'b1;
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

[hdl/rmth_dp.sv]
module rmth_dp import rmth_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic signed [31:0] i_sample,
    input  logic               i_restart,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic signed [31:0] o_median,
    output logic [11:0]        o_held,
    output logic               o_full_res
);
    logic [CW-1:0]      r_lcnt, r_ucnt;
    logic signed [31:0] r_last_med;
    logic signed [31:0] r_sample;
    logic               r_restart;
    logic               r_to_lower, r_cross, r_pend, r_dropped;
    // heap the current sift works on, 1 for the lower (max) heap
    logic               r_hsel;
    logic signed [31:0] r_val;    // value sifting
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_n;      // pop size after removal
    logic signed [31:0] r_top;    // popped top
    logic signed [31:0] r_lv;
    logic signed [31:0] r_o_med;
    logic [11:0]        r_o_held;
    logic               r_o_full;

    logic [CW-1:0] lcnt_e, ucnt_e;
    logic          to_lower_c, move_c, drop_c;

    assign lcnt_e = r_restart ? '0 : r_lcnt;
    assign ucnt_e = r_restart ? '0 : r_ucnt;
    always_comb begin
        to_lower_c = (lcnt_e == '0 && ucnt_e == '0) || (r_sample <= r_last_med);
        if (to_lower_c) begin
            move_c = (lcnt_e == ucnt_e + 1'b1);
            drop_c = (move_c ? ucnt_e : lcnt_e) >= CW'(HEAP_DEPTH);
        end else begin
            move_c = (ucnt_e == lcnt_e + 1'b1);
            drop_c = (move_c ? lcnt_e : ucnt_e) >= CW'(HEAP_DEPTH);
        end
    end

    // heap memories; the idle one sits at address 0 for the median read
    logic               l_we, u_we;
    logic [AW-1:0]      l_addr, u_addr;
    logic [31:0]        l_rd, u_rd;
    logic               h_we;
    logic [AW-1:0]      h_addr;
    logic [31:0]        h_wd;
    logic signed [31:0] h_rd;

    rmth_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_lower (
        .i_clk(i_clk), .i_we(l_we), .i_addr(l_addr), .i_wdata(h_wd), .o_rdata(l_rd));
    rmth_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_upper (
        .i_clk(i_clk), .i_we(u_we), .i_addr(u_addr), .i_wdata(h_wd), .o_rdata(u_rd));

    assign l_we   = r_hsel && h_we;
    assign u_we   = !r_hsel && h_we;
    assign l_addr = r_hsel ? h_addr : '0;
    assign u_addr = r_hsel ? '0 : h_addr;
    assign h_rd   = r_hsel ? l_rd : u_rd;

    function automatic logic outranks(input logic signed [31:0] a,
                                      input logic signed [31:0] b,
                                      input logic maxh);
        outranks = maxh ? (a > b) : (a < b);
    endfunction

    logic [CW:0]   lidx_w, ridx_w;
    logic          has_l, has_r;
    logic [CW-1:0] parent;
    assign lidx_w = {r_idx, 1'b1};
    assign ridx_w = lidx_w + 1'b1;
    assign has_l  = lidx_w < {1'b0, r_n};
    assign has_r  = ridx_w < {1'b0, r_n};
    assign parent = (r_idx - 1'b1) >> 1;

    // pop compares the held left child and the right child on the read port
    logic pick_l, pick_r, push_up;
    always_comb begin
        pick_l  = has_l && outranks(r_lv, r_val, r_hsel);
        pick_r  = has_r && outranks(h_rd, pick_l ? r_lv : r_val, r_hsel);
        push_up = outranks(r_val, h_rd, r_hsel);
    end

    // crossing value goes to the other heap, the sample to its own
    logic push_to_lower;
    assign push_to_lower = r_cross ? !r_to_lower : r_to_lower;

    always_comb begin
        h_we   = 1'b0;
        h_addr = '0;
        h_wd   = r_val;
        if (i_cmd.pop_rd_top || i_cmd.med_rd) h_addr = '0;
        if (i_cmd.pop_rd_last) h_addr = AW'(r_n);
        if (i_cmd.pop_rd_l) h_addr = AW'(lidx_w);
        if (i_cmd.pop_rd_r) h_addr = AW'(ridx_w);
        if (i_cmd.pop_step) begin
            h_we   = 1'b1;
            h_addr = AW'(r_idx);
            if (pick_r) h_wd = h_rd;
            else if (pick_l) h_wd = r_lv;
        end
        if (i_cmd.pop_fin || i_cmd.push_fin) begin
            h_we   = 1'b1;
            h_addr = AW'(r_idx);
        end
        if (i_cmd.push_rd) h_addr = AW'(parent);
        if (i_cmd.push_step) begin
            h_we   = 1'b1;
            h_addr = AW'(r_idx);
            if (push_up) h_wd = h_rd;
        end
    end

    assign o_sts.dropped   = drop_c;
    assign o_sts.move      = move_c;
    assign o_sts.pop_leaf  = !has_l;
    assign o_sts.pop_stop  = !(pick_l || pick_r);
    assign o_sts.push_root = (r_idx == '0);
    assign o_sts.push_stop = !push_up;
    assign o_sts.push_more = r_pend;

    logic signed [31:0] med_c;
    always_comb begin
        if (r_lcnt >= r_ucnt && r_lcnt != '0) med_c = l_rd;
        else if (r_ucnt != '0)                 med_c = u_rd;
        else                                   med_c = r_last_med;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt     <= '0;
            r_ucnt     <= '0;
            r_last_med <= '0;
        end else begin
            if (i_cmd.decide) begin
                r_lcnt <= lcnt_e;
                r_ucnt <= ucnt_e;
            end
            if (i_cmd.pop_rd_last) begin
                if (r_hsel) r_lcnt <= r_lcnt - 1'b1;
                else        r_ucnt <= r_ucnt - 1'b1;
            end
            if (i_cmd.push_start) begin
                if (push_to_lower) r_lcnt <= r_lcnt + 1'b1;
                else               r_ucnt <= r_ucnt + 1'b1;
            end
            if (i_cmd.med_ld) r_last_med <= med_c;
        end
    end

    // sift state and payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sample  <= i_sample;
            r_restart <= i_restart;
        end
        if (i_cmd.decide) begin
            r_to_lower <= to_lower_c;
            r_cross    <= move_c;
            r_pend     <= 1'b1;
            r_dropped  <= drop_c;
            r_hsel     <= to_lower_c;
            r_n        <= (to_lower_c ? lcnt_e : ucnt_e) - 1'b1;
        end
        if (i_cmd.pop_rd_last) r_top <= h_rd;
        if (i_cmd.pop_ld_last) begin
            r_val <= h_rd;
            r_idx <= '0;
        end
        if (i_cmd.pop_rd_r) r_lv <= h_rd;
        if (i_cmd.pop_step) begin
            if (pick_r)      r_idx <= CW'(ridx_w);
            else if (pick_l) r_idx <= CW'(lidx_w);
        end
        if (i_cmd.push_start) begin
            r_hsel <= push_to_lower;
            r_idx  <= push_to_lower ? r_lcnt : r_ucnt;
            if (r_cross) begin
                r_val   <= r_top;
                r_cross <= 1'b0;
            end else begin
                r_val  <= r_sample;
                r_pend <= 1'b0;
            end
        end
        if (i_cmd.push_step && push_up) r_idx <= parent;
        if (i_cmd.out_load) begin
            r_o_med  <= r_last_med;
            r_o_held <= 12'(r_lcnt) + 12'(r_ucnt);
            r_o_full <= r_dropped;
        end
    end

    assign o_median   = r_o_med;
    assign o_held     = r_o_held;
    assign o_full_res = r_o_full;
endmodule

[hdl/running_median_two_heaps.sv]
// Running median over signed 32-bit samples held in a max-heap (lower half)
// and a min-heap (upper half), each in a single-port RAM of HEAP_DEPTH words
// with registered read. One sample is worked on at a time: it is pushed and
// sifted up in its heap. When the receiving heap must first hand its top
// across, that top is popped, the last entry sifts down, and the top is then
// pushed into the other heap before the sample. A dropped sample skips the
// heaps and goes straight to its result beat. The next sample is accepted in
// the cycle after the result is loaded, even while that beat still waits; a
// later result holds until the waiting beat drains. A sample landing in a full
// heap is dropped, full_res flags it and the previous median repeats.
module running_median_two_heaps import rmth_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_sample,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_median,
    output logic [11:0]        o_held,
    output logic               o_full_res
);
    t_cmd cmd;
    t_sts sts;

    rmth_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_cmd(cmd));

    rmth_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_accept(i_in_valid && o_in_ready),
        .i_sample(i_sample), .i_restart(i_restart),
        .i_cmd(cmd), .o_sts(sts),
        .o_median(o_median), .o_held(o_held), .o_full_res(o_full_res));
endmodule
